FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker of the suppression core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: rtl/core/gbs_pkg.sv
// Shared constants, types and codes of the greedy box suppression core.
package gbs_pkg;

  localparam int MAX_KEPT_DEF   = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS      = 12;
  localparam int INDEX_W        = 16;
  localparam int COUNT_W        = 7;
  localparam int THR_W          = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;
  localparam int PIPE_DEPTH     = 4;

  // Result word layout, lowest bit first.
  localparam int OUT_KEPT_BIT  = 0;
  localparam int OUT_INDEX_LSB = 1;
  localparam int OUT_COUNT_LSB = OUT_INDEX_LSB + INDEX_W;
  localparam int OUT_FULL_BIT  = OUT_COUNT_LSB + COUNT_W;
  localparam int M_W           = ((OUT_FULL_BIT + 1 + 7) / 8) * 8;

  localparam logic [THR_W-1:0] LIMIT_RST = THR_W'(29491);
  localparam logic [THR_W-1:0] ETA_RST   = THR_W'(65536);
  localparam logic [THR_W-1:0] HALF_Q16  = THR_W'(32768);
  localparam logic [THR_W-1:0] ONE_Q16   = THR_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ETA        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZED = CFG_IDX_W'(2);

  localparam logic ACTION_CLEAR = 1'b0;
  localparam logic ACTION_BOX   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control from the sequencer to the overlap pipeline.
  typedef struct packed {
    logic issue;       // head cell holds a live kept box this cycle
    logic restart;     // new candidate accepted, clear the verdict
    logic normalized;  // 1: area = w*h, 0: area = (w+1)*(h+1)
  } ovl_ctrl_t;

endpackage

FILE: rtl/core/gbs_cell.sv
// One storage cell of the kept-box ring: loads a new box or takes its neighbor's.
module gbs_cell #(
  parameter int WIDTH = 4 * gbs_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             shift,
  input  logic             load,
  input  logic [WIDTH-1:0] load_data,
  input  logic [WIDTH-1:0] next_data,
  output logic [WIDTH-1:0] data
);
  import gbs_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= next_data;
    end
  end

endmodule

FILE: rtl/core/gbs_overlap.sv
// Pipelined overlap test of the candidate against one kept box per cycle.
module gbs_overlap #(
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gbs_pkg::ovl_ctrl_t        ctrl,
  input  logic [4*COORD_BITS-1:0]   cand,
  input  logic [4*COORD_BITS-1:0]   box,
  input  logic [gbs_pkg::THR_W-1:0] threshold,
  output logic                      fail
);
  import gbs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = ((CB > FRAC_BITS) ? CB : FRAC_BITS) + 1;
  localparam int AW = 2 * EW;
  localparam int UW = AW + 1;
  localparam int LW = AW + 16;
  localparam int RW = UW + THR_W;
  localparam logic [EW-1:0] ONE_LEN = EW'(1) << FRAC_BITS;

  // Edge length with the pixel-mode extra unit; top bit flags a positive span.
  function automatic logic [EW:0] span(input logic [CB-1:0] lo, input logic [CB-1:0] hi,
                                       input logic norm);
    logic signed [CB:0] d;
    logic [EW-1:0]      len;
    d   = $signed({hi[CB-1], hi}) - $signed({lo[CB-1], lo});
    len = EW'(d[CB-1:0]) + (norm ? '0 : ONE_LEN);
    return {(!d[CB] && (d != '0)), len};
  endfunction

  function automatic logic [CB-1:0] smax(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  function automatic logic [CB-1:0] smin(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  logic [CB-1:0] c_x0, c_y0, c_x1, c_y1;
  logic [CB-1:0] b_x0, b_y0, b_x1, b_y1;
  logic [EW:0]   iw_s, ih_s, bw_s, bh_s, cw_s, ch_s;

  assign {c_y1, c_x1, c_y0, c_x0} = cand;
  assign {b_y1, b_x1, b_y0, b_x0} = box;

  assign iw_s = span(smax(c_x0, b_x0), smin(c_x1, b_x1), ctrl.normalized);
  assign ih_s = span(smax(c_y0, b_y0), smin(c_y1, b_y1), ctrl.normalized);
  assign bw_s = span(b_x0, b_x1, ctrl.normalized);
  assign bh_s = span(b_y0, b_y1, ctrl.normalized);
  assign cw_s = span(c_x0, c_x1, ctrl.normalized);
  assign ch_s = span(c_y0, c_y1, ctrl.normalized);

  // Candidate area: the candidate holds still for the whole item.
  logic [EW-1:0] c_w, c_h;
  logic          c_nz;
  logic [AW-1:0] c_area;

  always_ff @(posedge clk) begin
    c_w    <= cw_s[EW-1:0];
    c_h    <= ch_s[EW-1:0];
    c_nz   <= cw_s[EW] && ch_s[EW];
    c_area <= c_nz ? AW'(c_w) * AW'(c_h) : '0;
  end

  logic          v1, v2, v3, v4;
  logic [EW-1:0] i_w, i_h, b_w, b_h;
  logic          i_nz, b_nz;
  logic [AW-1:0] inter2, b_area, inter3;
  logic [UW-1:0] uni;
  logic [LW-1:0] lhs;
  logic [RW-1:0] rhs;
  logic          nz4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // intersection and kept box extents
    i_w  <= iw_s[EW-1:0];
    i_h  <= ih_s[EW-1:0];
    i_nz <= iw_s[EW] && ih_s[EW];
    b_w  <= bw_s[EW-1:0];
    b_h  <= bh_s[EW-1:0];
    b_nz <= bw_s[EW] && bh_s[EW];
    // areas
    inter2 <= i_nz ? AW'(i_w) * AW'(i_h) : '0;
    b_area <= b_nz ? AW'(b_w) * AW'(b_h) : '0;
    // union never goes negative: the intersection fits in either box
    uni    <= UW'(c_area) + UW'(b_area) - UW'(inter2);
    inter3 <= inter2;
    // inter * 2^16 against threshold * union
    lhs <= {inter3, 16'b0};
    rhs <= RW'(uni) * RW'(threshold);
    nz4 <= (inter3 != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail <= 1'b0;
    end else if (ctrl.restart) begin
      fail <= 1'b0;
    end else if (v4 && nz4 && (RW'(lhs) > rhs)) begin
      fail <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/greedy_box_suppression_core.sv
// A box candidate passes through ST_ROTATE, ST_DRAIN and ST_FINISH before its result is registered;
//   a clear goes straight from ST_IDLE to ST_FINISH. A candidate takes one full turn of the kept-box
//   ring past the single overlap pipeline, a drain of that pipeline and a decision in ST_FINISH.
// Input is accepted only in ST_IDLE. The result register lets the next item enter while it waits.
// Reset (synchronous, rst high) empties the store count, loads the register defaults
//   and reloads the working threshold; the box cells themselves are not cleared.
module greedy_box_suppression_core #(
  parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF,
  localparam int S_W = ((gbs_pkg::INDEX_W + 4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [S_W-1:0]                 s_tdata,   // candidate_index, x_min, y_min, x_max, y_max
  input  logic                           s_tuser,   // action
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [gbs_pkg::M_W-1:0]        m_tdata    // kept, index_out, kept_count, store_full
);
  import gbs_pkg::*;

  localparam int BOX_W   = 4 * COORD_BITS;
  localparam int IW      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW      = $clog2(MAX_KEPT + 1);
  localparam int DRAIN_W = $clog2(PIPE_DEPTH);

  // Configuration registers
  logic [THR_W-1:0] overlap_limit;
  logic [THR_W-1:0] eta;
  logic             normalized_boxes;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_limit    <= LIMIT_RST;
      eta              <= ETA_RST;
      normalized_boxes <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT:      overlap_limit    <= cfg_data[THR_W-1:0];
        CFG_ETA:        eta              <= cfg_data[THR_W-1:0];
        CFG_NORMALIZED: normalized_boxes <= cfg_data[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Sequencer
  state_t state, state_next;
  logic [IW-1:0]      rot_cnt;
  logic [DRAIN_W-1:0] drain_cnt;
  logic               in_xfer;
  logic               rot_last, drain_last;
  logic               shift_en, finish_go;

  assign in_xfer    = s_tvalid && s_tready;
  assign rot_last   = (rot_cnt == IW'(MAX_KEPT - 1));
  assign drain_last = (drain_cnt == DRAIN_W'(PIPE_DEPTH - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (s_tuser == ACTION_CLEAR) ? ST_FINISH : ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (rot_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    shift_en  = 1'b0;
    finish_go = 1'b0;
    case (state)
      ST_IDLE:   s_tready  = 1'b1;
      ST_ROTATE: shift_en  = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: finish_go = !m_tvalid || m_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rot_cnt   <= '0;
      drain_cnt <= '0;
    end else begin
      state <= state_next;
      // advance the ring position; a full turn brings every box home
      if (shift_en) begin
        rot_cnt <= rot_last ? '0 : rot_cnt + IW'(1);
      end
      if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + DRAIN_W'(1);
      end else begin
        drain_cnt <= '0;
      end
    end
  end

  // Held item
  logic [BOX_W-1:0]   cand;
  logic [INDEX_W-1:0] cand_index;
  logic               cand_action;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cand        <= s_tdata[INDEX_W +: BOX_W];
      cand_index  <= s_tdata[INDEX_W-1:0];
      cand_action <= s_tuser;
    end
  end

  // Kept-box ring: cell 0 feeds the overlap pipeline, each cell takes its
  // upper neighbor's box on every shift, the top cell takes cell 0's.
  logic [CW-1:0]    kept_total, kept_total_next;
  logic [BOX_W-1:0] ring [MAX_KEPT];
  logic             load_en;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbs_cell #(
      .WIDTH(BOX_W)
    ) u_cell (
      .clk      (clk),
      .shift    (shift_en),
      .load     (load_en && (kept_total == CW'(i))),
      .load_data(cand),
      .next_data(ring[(i + 1) % MAX_KEPT]),
      .data     (ring[i])
    );
  end

  // Overlap pipeline
  logic [THR_W-1:0] working_threshold;
  ovl_ctrl_t        ctrl;
  logic             fail;

  assign ctrl.issue      = shift_en && (CW'(rot_cnt) < kept_total);
  assign ctrl.restart    = in_xfer;
  assign ctrl.normalized = normalized_boxes;

  gbs_overlap #(
    .COORD_BITS(COORD_BITS)
  ) u_overlap (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cand     (cand),
    .box      (ring[0]),
    .threshold(working_threshold),
    .fail     (fail)
  );

  // Decision: store a survivor if there is room and decay the threshold; a clear resets both
  logic                 is_box, pass, room, full_flag, decay_on;
  logic [2*THR_W-1:0]   decay_prod;

  assign is_box     = (cand_action == ACTION_BOX);
  assign pass       = is_box && !fail;
  assign room       = (kept_total < CW'(MAX_KEPT));
  assign full_flag  = pass && !room;
  assign load_en    = finish_go && pass && room;
  assign decay_on   = pass && (eta < ONE_Q16) && (working_threshold > HALF_Q16);
  assign decay_prod = (2*THR_W)'(working_threshold) * (2*THR_W)'(eta);

  always_comb begin
    kept_total_next = kept_total;
    if (!is_box) begin
      kept_total_next = '0;
    end else if (pass && room) begin
      kept_total_next = kept_total + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_total        <= '0;
      working_threshold <= LIMIT_RST;
    end else if (finish_go) begin
      kept_total <= kept_total_next;
      if (!is_box) begin
        working_threshold <= overlap_limit;
      end else if (decay_on) begin
        working_threshold <= decay_prod[THR_W+15:16];
      end
    end
  end

  // Result register: hold until the transfer completes
  logic [M_W-1:0] result_word;

  always_comb begin
    result_word                           = '0;
    result_word[OUT_KEPT_BIT]             = pass;
    result_word[OUT_INDEX_LSB +: INDEX_W] = cand_index;
    result_word[OUT_COUNT_LSB +: COUNT_W] = COUNT_W'(kept_total_next);
    result_word[OUT_FULL_BIT]             = full_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      m_tdata <= result_word;
    end
  end

endmodule

FILE: rtl/core/gbs_checker.sv
// Port-level checker of the suppression core and its bind to the top level.
`include "assert_macros.svh"

module gbs_checker #(
  parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [gbs_pkg::M_W-1:0] m_tdata
);
  import gbs_pkg::*;

  logic [COUNT_W-1:0] count;
  assign count = m_tdata[OUT_COUNT_LSB +: COUNT_W];

  // a stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // one item at a time: no transfer right after a transfer
  `ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)
  // a full store only rejects a box that survived
  `ASSERT_IMPLIES(a_full_kept, clk, rst, m_tvalid && m_tdata[OUT_FULL_BIT], m_tdata[OUT_KEPT_BIT])
  // a full store reports every slot taken
  `ASSERT_IMPLIES(a_full_count, clk, rst, m_tvalid && m_tdata[OUT_FULL_BIT], count == COUNT_W'(MAX_KEPT))
  // the count never passes the store size
  `ASSERT_IMPLIES(a_count_max, clk, rst, m_tvalid, (MAX_KEPT > 127) || (count <= COUNT_W'(MAX_KEPT)))

endmodule

bind greedy_box_suppression_core gbs_checker #(
  .MAX_KEPT(MAX_KEPT)
) u_gbs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
